FILE: rtl/core/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned AccW   = 31;  // 1 lead bit + 5 x 6 continuation bits
  localparam int unsigned PendW  = 3;
  localparam int unsigned QDepth = 3;   // result queue entries
  localparam int unsigned QCntW  = 2;

  localparam logic [UnitW-1:0] HiSurrBase = 16'hD800;
  localparam logic [UnitW-1:0] LoSurrBase = 16'hDC00;
  localparam logic [20:0]      SuppBase   = 21'h10000;
  localparam logic [5:0]       ContMask   = 6'h3F;

  // lead byte thresholds
  localparam logic [ByteW-1:0] Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Lead4 = 8'hF0;
  localparam logic [ByteW-1:0] Lead5 = 8'hF8;
  localparam logic [ByteW-1:0] Lead6 = 8'hFC;
  localparam logic [ByteW-1:0] LeadX = 8'hFE;
  localparam logic [ByteW-1:0] ContLo = 8'h80;

  typedef struct packed {
    logic [UnitW-1:0] unit;
    logic             last;
    logic             bad;
  } res_t;

  typedef struct packed {
    logic [PendW-1:0] pend;
    logic [AccW-1:0]  acc;
    logic             drop;
  } state_t;

  typedef struct packed {
    state_t     nxt;
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } step_t;

endpackage

FILE: rtl/core/utf8_to_utf16_transcoder_core.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Streaming UTF-8 to UTF-16 transcoder with surrogate pair output.
// ----------------------------------------------------------------------------
// Takes one UTF-8 byte per cycle, unless the result queue holds back decoding,
// and returns UTF-16 code units. Each byte passes an input register, one step
// of decode logic and lands in a three-entry result queue; the first unit of a
// code point reaches the output once its last byte has passed the input
// register and been decoded into the queue. A code point above 0xFFFF yields
// two units, which the queue absorbs, so with a sink that is always ready the
// block sustains one byte per cycle. The byte in the input register is decoded
// whenever the queue, after this cycle's output handshake, holds at most one
// unit; a new input request is taken whenever the input register is empty or
// its byte is being decoded. Errors give a single zero unit with tlast and
// tuser set, and the rest of the string up to its last byte is dropped.
module utf8_to_utf16_transcoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] code_unit
  output logic        m_axis_tlast,   // final_unit
  output logic        m_axis_tuser    // bad_sequence
);

  logic                             in_v_q;
  logic [u8u16_pkg::ByteW-1:0]      in_byte_q;
  logic                             in_last_q;
  u8u16_pkg::state_t                st_q, st_d;
  u8u16_pkg::step_t                 step;
  u8u16_pkg::res_t                  q_q [u8u16_pkg::QDepth];
  u8u16_pkg::res_t                  q_d [u8u16_pkg::QDepth];
  logic [u8u16_pkg::QCntW-1:0]      cnt_q, cnt_d, cnt_left;
  logic                             deq, fire;

  u8u16_decode u_decode (
    .st_i   (st_q),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .step_o (step)
  );

  assign deq           = m_axis_tvalid && m_axis_tready;
  assign cnt_left      = cnt_q - u8u16_pkg::QCntW'(deq);
  assign fire          = in_v_q && (cnt_left <= 2'd1);
  assign s_axis_tready = !in_v_q || fire;

  assign m_axis_tvalid = (cnt_q != '0);
  assign m_axis_tdata  = q_q[0].unit;
  assign m_axis_tlast  = q_q[0].last;
  assign m_axis_tuser  = q_q[0].bad;

  assign st_d = fire ? step.nxt : st_q;

  always_comb begin
    for (int i = 0; i < u8u16_pkg::QDepth; i++) begin
      if (deq && i < u8u16_pkg::QDepth - 1) q_d[i] = q_q[i+1];
      else                                  q_d[i] = q_q[i];
    end
    cnt_d = cnt_left;
    if (fire) begin
      if (step.num != 2'd0) q_d[cnt_left] = step.r0;
      if (step.num == 2'd2) q_d[u8u16_pkg::QCntW'(cnt_left + 2'd1)] = step.r1;
      cnt_d = cnt_left + step.num;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
      st_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (s_axis_tready) in_v_q <= s_axis_tvalid;
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    q_q <= q_d;
  end

endmodule

FILE: rtl/core/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// One UTF-8 byte step: next sequence state and up to two UTF-16 results.
// ----------------------------------------------------------------------------
module u8u16_decode (
  input  u8u16_pkg::state_t             st_i,
  input  logic [u8u16_pkg::ByteW-1:0]   byte_i,
  input  logic                          last_i,
  output u8u16_pkg::step_t              step_o
);

  logic                            err;
  logic [u8u16_pkg::PendW-1:0]     pend;
  logic [u8u16_pkg::AccW-1:0]      acc;
  logic                            too_big;
  logic [20:0]                     v;

  assign too_big = (|acc[u8u16_pkg::AccW-1:21]) || (acc[20] && (|acc[19:16]));
  assign v       = acc[20:0] - u8u16_pkg::SuppBase;

  always_comb begin
    step_o     = '0;
    step_o.nxt = st_i;
    err        = 1'b0;
    pend       = st_i.pend;
    acc        = st_i.acc;

    if (st_i.drop) begin
      // skip the rest of a failed string
      if (last_i) step_o.nxt.drop = 1'b0;
    end else begin
      if (st_i.pend == '0) begin
        if (byte_i < u8u16_pkg::ContLo) begin
          acc = u8u16_pkg::AccW'(byte_i);
        end else if (byte_i < u8u16_pkg::Lead2) begin
          err = 1'b1;
        end else if (byte_i < u8u16_pkg::Lead3) begin
          acc = u8u16_pkg::AccW'(byte_i[4:0]); pend = 3'd1;
        end else if (byte_i < u8u16_pkg::Lead4) begin
          acc = u8u16_pkg::AccW'(byte_i[3:0]); pend = 3'd2;
        end else if (byte_i < u8u16_pkg::Lead5) begin
          acc = u8u16_pkg::AccW'(byte_i[2:0]); pend = 3'd3;
        end else if (byte_i < u8u16_pkg::Lead6) begin
          acc = u8u16_pkg::AccW'(byte_i[1:0]); pend = 3'd4;
        end else if (byte_i < u8u16_pkg::LeadX) begin
          acc = u8u16_pkg::AccW'(byte_i[0]);   pend = 3'd5;
        end else begin
          err = 1'b1;
        end
      end else begin
        if (byte_i < u8u16_pkg::ContLo || byte_i >= u8u16_pkg::Lead2) begin
          err = 1'b1;
        end else begin
          acc  = {st_i.acc[u8u16_pkg::AccW-7:0], byte_i[5:0] & u8u16_pkg::ContMask};
          pend = st_i.pend - 3'd1;
        end
      end

      if (!err) begin
        if (pend != '0) begin
          if (last_i) begin
            err = 1'b1;
          end else begin
            step_o.nxt.pend = pend;
            step_o.nxt.acc  = acc;
          end
        end else begin
          step_o.nxt.pend = '0;
          step_o.nxt.acc  = '0;
          if (too_big) begin
            err = 1'b1;
          end else if (acc[20:16] == '0) begin
            step_o.num     = 2'd1;
            step_o.r0.unit = acc[15:0];
            step_o.r0.last = last_i;
          end else begin
            // surrogate pair, high unit first
            step_o.num     = 2'd2;
            step_o.r0.unit = u8u16_pkg::HiSurrBase | {6'd0, v[19:10]};
            step_o.r1.unit = u8u16_pkg::LoSurrBase | {6'd0, v[9:0]};
            step_o.r1.last = last_i;
          end
        end
      end

      if (err) begin
        step_o.nxt.pend = '0;
        step_o.nxt.acc  = '0;
        step_o.nxt.drop = !last_i;
        step_o.num      = 2'd1;
        step_o.r0.unit  = '0;
        step_o.r0.last  = 1'b1;
        step_o.r0.bad   = 1'b1;
        step_o.r1       = '0;
      end
    end
  end

endmodule
